>>> rtl/core/mrp_pkg.sv
// Shared types, constants and the CRC-16 byte step of the Modbus RTU response parser.
package mrp_pkg;

    // Frame geometry.
    localparam int MAX_DATA_BYTES = 16;
    localparam int FRAME_BYTES    = 32;
    localparam int IDX_W          = $clog2(FRAME_BYTES);
    localparam int CNT_W          = 5;
    localparam int CFG_IDX_W      = 3;

    // Write echo carries six bytes after the function code, CRC included.
    localparam logic [CNT_W-1:0] WRITE_BYTES = CNT_W'(6);

    // Frame positions of the first data byte and the last analog byte.
    localparam logic [IDX_W-1:0] FIRST_DATA  = IDX_W'(3);
    localparam logic [IDX_W-1:0] ANALOG_LAST = IDX_W'(10);

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_SLAVE_ADDR  = 8'd254;
    localparam logic [7:0] RST_FC_COIL     = 8'h01;
    localparam logic [7:0] RST_FC_INPUT    = 8'h02;
    localparam logic [7:0] RST_FC_REGISTER = 8'h04;
    localparam logic [7:0] RST_FC_SINGLE   = 8'd5;
    localparam logic [7:0] RST_FC_MULTI    = 8'd15;

    // Modbus CRC-16, reflected form.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR  = 3'd0,
        CFG_FC_COIL     = 3'd1,
        CFG_FC_INPUT    = 3'd2,
        CFG_FC_REGISTER = 3'd3,
        CFG_FC_SINGLE   = 3'd4,
        CFG_FC_MULTI    = 3'd5
    } cfg_idx_t;

    // Kind of a completed frame.
    typedef enum logic [1:0] {
        KIND_COIL  = 2'd0,
        KIND_INPUT = 2'd1,
        KIND_REG   = 2'd2,
        KIND_WRITE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] fc_coil_read;
        logic [7:0] fc_input_read;
        logic [7:0] fc_register_read;
        logic [7:0] fc_single_write;
        logic [7:0] fc_multi_write;
    } cfg_t;

    typedef struct packed {
        kind_t       frame_kind;
        logic        crc_good;
        logic [7:0]  coil_bits;
        logic [7:0]  input_bits;
        logic [15:0] analog_ch0;
        logic [15:0] analog_ch1;
        logic [15:0] analog_ch2;
        logic [15:0] analog_ch3;
        logic [15:0] good_reads;
    } res_t;

    // Commands from the sequencer to the CRC unit.
    typedef struct packed {
        logic init;
        logic step;
    } crc_ctl_t;

    // One byte of the CRC-16, least significant bit first.
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/mrp_rx_if.sv
// Input byte channel of the Modbus RTU response parser.
interface mrp_rx_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink (input valid, mode, rx_byte, output ready);
endinterface

>>> rtl/core/mrp_res_if.sv
// Result channel of the Modbus RTU response parser.
interface mrp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic        crc_good;
    logic [7:0]  coil_bits;
    logic [7:0]  input_bits;
    logic        stop_button;
    logic        barrier_touch;
    logic [15:0] analog_ch0;
    logic [15:0] analog_ch1;
    logic [15:0] analog_ch2;
    logic [15:0] analog_ch3;
    logic [15:0] good_reads;

    modport source (
        output valid, frame_kind, crc_good, coil_bits, input_bits, stop_button,
               barrier_touch, analog_ch0, analog_ch1, analog_ch2, analog_ch3, good_reads,
        input  ready
    );
    modport sink (
        input  valid, frame_kind, crc_good, coil_bits, input_bits, stop_button,
               barrier_touch, analog_ch0, analog_ch1, analog_ch2, analog_ch3, good_reads,
        output ready
    );
endinterface

>>> rtl/core/mrp_cfg_if.sv
// Configuration write channel of the Modbus RTU response parser.
interface mrp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mrp_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mrp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mrp_crc_unit.sv
// Shared CRC-16 unit: one frame byte folded into the running CRC per cycle in which step is set.
module mrp_crc_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  mrp_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data,
    output logic [15:0]       crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // Start value on init, one byte step on step.
    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
        begin
            crc_next = mrp_pkg::CRC_INIT;
        end
        else if (ctl.step)
        begin
            crc_next = mrp_pkg::crc_byte(crc_reg, data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= mrp_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> rtl/core/mrp_ctrl.sv
// Frame parser and end-of-frame sequencer that walks the frame store through the CRC unit.
module mrp_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mrp_pkg::cfg_t              cfg,
    // Byte input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_mode,
    input  logic [7:0]                 in_byte,
    // Frame store
    output logic                       ram_we,
    output logic [mrp_pkg::IDX_W-1:0]  ram_waddr,
    output logic [7:0]                 ram_wdata,
    output logic                       ram_re,
    output logic [mrp_pkg::IDX_W-1:0]  ram_raddr,
    input  logic [7:0]                 ram_rdata,
    // CRC unit
    output mrp_pkg::crc_ctl_t          crc_ctl,
    output logic [7:0]                 crc_data,
    input  logic [15:0]                crc_val,
    // Result handoff
    output logic                       res_valid,
    input  logic                       res_ready,
    output mrp_pkg::res_t              res
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_FUNC   = 11'b000_0000_0010,
        S_COUNT  = 11'b000_0000_0100,
        S_DATA   = 11'b000_0000_1000,
        S_WRITE  = 11'b000_0001_0000,
        S_LOCK   = 11'b000_0010_0000,
        S_WALK   = 11'b000_0100_0000,
        S_CDRAIN = 11'b000_1000_0000,
        S_UPD    = 11'b001_0000_0000,
        S_UDRAIN = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

    localparam int IW = mrp_pkg::IDX_W;
    localparam int CW = mrp_pkg::CNT_W;

    state_t                       state_reg, state_next;
    logic [IW-1:0]                wr_idx_reg, wr_idx_next;
    logic [CW-1:0]                bc_reg, bc_next;
    logic [CW-1:0]                dcount_reg, dcount_next;
    mrp_pkg::kind_t               kind_reg, kind_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [IW-1:0]                rd_addr_reg, rd_addr_next;
    logic                         rd_upd_reg, rd_upd_next;
    logic [mrp_pkg::FRAME_BYTES-1:0] valid_bits_reg, valid_bits_next;
    logic                         good_lo_reg, good_lo_next;
    logic                         good_reg, good_next;
    logic [7:0]                   coils_reg, coils_next;
    logic [7:0]                   inputs_reg, inputs_next;
    logic [15:0]                  analog_reg [4];
    logic [15:0]                  analog_next [4];
    logic [15:0]                  good_cnt_reg, good_cnt_next;

    logic                         in_fire;
    logic [CW-1:0]                bc_inc;
    logic [IW-1:0]                crc_len;
    logic [IW-1:0]                crc_last;
    logic [IW-1:0]                upd_last;
    logic [7:0]                   rd_byte;
    logic                         good_hi;
    logic [IW-1:0]                ana_off;
    logic [1:0]                   ana_sel;

    assign in_ready = (state_reg inside {S_IDLE, S_FUNC, S_COUNT, S_DATA, S_WRITE, S_LOCK});
    assign in_fire  = in_valid && in_ready;
    assign bc_inc   = bc_reg + CW'(1);

    // CRC covers the frame without its two trailing CRC bytes.
    assign crc_len  = (kind_reg == mrp_pkg::KIND_WRITE)
                    ? IW'(mrp_pkg::WRITE_BYTES)
                    : IW'(dcount_reg) + mrp_pkg::FIRST_DATA;
    assign crc_last = crc_len + IW'(1);
    assign upd_last = (kind_reg == mrp_pkg::KIND_REG) ? mrp_pkg::ANALOG_LAST
                                                      : mrp_pkg::FIRST_DATA;

    // Entries never written since reset read as zero.
    assign rd_byte  = valid_bits_reg[rd_addr_reg] ? ram_rdata : 8'h00;
    assign good_hi  = good_lo_reg && (crc_val[15:8] == rd_byte);
    assign crc_data = rd_byte;
    assign ana_off  = rd_addr_reg - mrp_pkg::FIRST_DATA;
    assign ana_sel  = ana_off[2:1];

    // Parser and sequencer.
    always_comb
    begin
        state_next    = state_reg;
        wr_idx_next   = wr_idx_reg;
        bc_next       = bc_reg;
        dcount_next   = dcount_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        good_cnt_next = good_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = wr_idx_reg;
        ram_wdata     = in_byte;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;
        crc_ctl       = '0;
        res_valid     = 1'b0;

        // Each returned byte of the checked span is folded into the CRC.
        crc_ctl.step  = rd_vld_reg && !rd_upd_reg && (rd_addr_reg < crc_len);

        if (in_fire && in_mode)
        begin
            // Resync: back to idle from any parse state.
            state_next  = S_IDLE;
            wr_idx_next = '0;
            bc_next     = '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        wr_idx_next = '0;
                        if (in_byte == cfg.slave_address)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = '0;
                            wr_idx_next = IW'(1);
                            state_next  = S_FUNC;
                        end
                        else
                        begin
                            state_next = S_LOCK;
                        end
                    end
                end
                S_FUNC:
                begin
                    if (in_fire)
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + IW'(1);
                        bc_next     = '0;
                        if (in_byte == cfg.fc_coil_read)
                        begin
                            kind_next  = mrp_pkg::KIND_COIL;
                            state_next = S_COUNT;
                        end
                        else if (in_byte == cfg.fc_input_read)
                        begin
                            kind_next  = mrp_pkg::KIND_INPUT;
                            state_next = S_COUNT;
                        end
                        else if (in_byte == cfg.fc_register_read)
                        begin
                            kind_next  = mrp_pkg::KIND_REG;
                            state_next = S_COUNT;
                        end
                        else if (in_byte == cfg.fc_single_write ||
                                 in_byte == cfg.fc_multi_write)
                        begin
                            kind_next  = mrp_pkg::KIND_WRITE;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            wr_idx_next = '0;
                            state_next  = S_LOCK;
                        end
                    end
                end
                S_COUNT:
                begin
                    if (in_fire)
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + IW'(1);
                        bc_next     = '0;
                        if (in_byte <= 8'(mrp_pkg::MAX_DATA_BYTES))
                        begin
                            dcount_next = in_byte[CW-1:0];
                            state_next  = S_DATA;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                S_DATA:
                begin
                    if (in_fire)
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + IW'(1);
                        bc_next     = bc_inc;
                        // Data bytes plus the two CRC bytes complete the frame.
                        if (bc_inc >= dcount_reg + CW'(2))
                        begin
                            wr_idx_next = '0;
                            bc_next     = '0;
                            idx_next    = '0;
                            crc_ctl.init = 1'b1;
                            state_next  = S_WALK;
                        end
                    end
                end
                S_WRITE:
                begin
                    if (in_fire)
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + IW'(1);
                        bc_next     = bc_inc;
                        if (bc_inc >= mrp_pkg::WRITE_BYTES)
                        begin
                            wr_idx_next = '0;
                            bc_next     = '0;
                            idx_next    = '0;
                            crc_ctl.init = 1'b1;
                            state_next  = S_WALK;
                        end
                    end
                end
                S_LOCK:
                begin
                    // Bytes are dropped until a resync arrives.
                end
                S_WALK:
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + IW'(1);
                    if (idx_reg == crc_last)
                    begin
                        state_next = S_CDRAIN;
                    end
                end
                S_CDRAIN:
                begin
                    // Last CRC byte is compared this cycle.
                    if (good_hi && kind_reg != mrp_pkg::KIND_WRITE)
                    begin
                        good_cnt_next = good_cnt_reg + 16'd1;
                        idx_next      = mrp_pkg::FIRST_DATA;
                        state_next    = S_UPD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                S_UPD:
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + IW'(1);
                    if (idx_reg == upd_last)
                    begin
                        state_next = S_UDRAIN;
                    end
                end
                S_UDRAIN:
                begin
                    state_next = S_EMIT;
                end
                S_EMIT:
                begin
                    res_valid = 1'b1;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    // Read return: CRC compare and held data updates.
    always_comb
    begin
        rd_vld_next     = ram_re;
        rd_addr_next    = ram_raddr;
        rd_upd_next     = (state_reg == S_UPD);
        valid_bits_next = valid_bits_reg;
        good_lo_next    = good_lo_reg;
        good_next       = good_reg;
        coils_next      = coils_reg;
        inputs_next     = inputs_reg;
        for (int i = 0; i < 4; i++)
        begin
            analog_next[i] = analog_reg[i];
        end

        if (ram_we)
        begin
            valid_bits_next[ram_waddr] = 1'b1;
        end

        if (rd_vld_reg && !rd_upd_reg)
        begin
            if (rd_addr_reg == crc_len)
            begin
                good_lo_next = (crc_val[7:0] == rd_byte);
            end
            if (rd_addr_reg == crc_last)
            begin
                good_next = good_hi;
            end
        end

        if (rd_vld_reg && rd_upd_reg)
        begin
            case (kind_reg)
                mrp_pkg::KIND_COIL:
                begin
                    coils_next = rd_byte;
                end
                mrp_pkg::KIND_INPUT:
                begin
                    inputs_next = rd_byte;
                end
                default:
                begin
                    // Odd frame positions carry the high byte of a word.
                    if (rd_addr_reg[0])
                    begin
                        analog_next[ana_sel] = {rd_byte, analog_reg[ana_sel][7:0]};
                    end
                    else
                    begin
                        analog_next[ana_sel] = {analog_reg[ana_sel][15:8], rd_byte};
                    end
                end
            endcase
        end
    end

    assign res.frame_kind = kind_reg;
    assign res.crc_good   = good_reg;
    assign res.coil_bits  = coils_reg;
    assign res.input_bits = inputs_reg;
    assign res.analog_ch0 = analog_reg[0];
    assign res.analog_ch1 = analog_reg[1];
    assign res.analog_ch2 = analog_reg[2];
    assign res.analog_ch3 = analog_reg[3];
    assign res.good_reads = good_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wr_idx_reg     <= '0;
            bc_reg         <= '0;
            dcount_reg     <= '0;
            kind_reg       <= mrp_pkg::KIND_COIL;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_addr_reg    <= '0;
            rd_upd_reg     <= 1'b0;
            valid_bits_reg <= '0;
            good_lo_reg    <= 1'b0;
            good_reg       <= 1'b0;
            coils_reg      <= '0;
            inputs_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                analog_reg[i] <= '0;
            end
            good_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_idx_reg     <= wr_idx_next;
            bc_reg         <= bc_next;
            dcount_reg     <= dcount_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            rd_vld_reg     <= rd_vld_next;
            rd_addr_reg    <= rd_addr_next;
            rd_upd_reg     <= rd_upd_next;
            valid_bits_reg <= valid_bits_next;
            good_lo_reg    <= good_lo_next;
            good_reg       <= good_next;
            coils_reg      <= coils_next;
            inputs_reg     <= inputs_next;
            for (int i = 0; i < 4; i++)
            begin
                analog_reg[i] <= analog_next[i];
            end
            good_cnt_reg   <= good_cnt_next;
        end
    end

endmodule

>>> rtl/core/modbus_rtu_response_parser_unit.sv
// Top level of the Modbus RTU response parser.
//
// Takes one response byte per accepted request and checks address, function code and byte
// count as the bytes arrive. When a frame is complete the input stalls while a sequencer
// walks the 32-byte frame store through a shared CRC-16 unit, one stored byte per cycle over
// its single registered read port, and compares the two received CRC bytes. A good read
// then loads the held data from the store (one byte for a coil or input read, eight for a
// register read), and the result is handed to an output register. The parser takes the
// next byte while the result waits in the output register; a second result that finds the
// register still full stalls the input until the first is taken. A wrong slave address or
// an unknown function code locks the parser until a resync request. Configuration
// registers are written through the cfg channel, which is always ready.
module modbus_rtu_response_parser_unit (
    input  logic     clk,
    input  logic     rst_n,
    mrp_rx_if.sink   rx,
    mrp_res_if.source result,
    mrp_cfg_if.sink  cfg
);

    mrp_pkg::cfg_t      cfg_reg, cfg_next;
    mrp_pkg::res_t      out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic                         ram_we;
    logic [mrp_pkg::IDX_W-1:0]    ram_waddr;
    logic [7:0]                   ram_wdata;
    logic                         ram_re;
    logic [mrp_pkg::IDX_W-1:0]    ram_raddr;
    logic [7:0]                   ram_rdata;
    mrp_pkg::crc_ctl_t            crc_ctl;
    logic [7:0]                   crc_data;
    logic [15:0]                  crc_val;
    logic                         res_valid;
    logic                         res_ready;
    mrp_pkg::res_t                res;

    // Configuration register writes.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (mrp_pkg::cfg_idx_t'(cfg.index))
                mrp_pkg::CFG_SLAVE_ADDR:  cfg_next.slave_address    = cfg.data;
                mrp_pkg::CFG_FC_COIL:     cfg_next.fc_coil_read     = cfg.data;
                mrp_pkg::CFG_FC_INPUT:    cfg_next.fc_input_read    = cfg.data;
                mrp_pkg::CFG_FC_REGISTER: cfg_next.fc_register_read = cfg.data;
                mrp_pkg::CFG_FC_SINGLE:   cfg_next.fc_single_write  = cfg.data;
                mrp_pkg::CFG_FC_MULTI:    cfg_next.fc_multi_write   = cfg.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Output register between the sequencer and the result channel.
    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address    <= mrp_pkg::RST_SLAVE_ADDR;
            cfg_reg.fc_coil_read     <= mrp_pkg::RST_FC_COIL;
            cfg_reg.fc_input_read    <= mrp_pkg::RST_FC_INPUT;
            cfg_reg.fc_register_read <= mrp_pkg::RST_FC_REGISTER;
            cfg_reg.fc_single_write  <= mrp_pkg::RST_FC_SINGLE;
            cfg_reg.fc_multi_write   <= mrp_pkg::RST_FC_MULTI;
            out_reg                  <= '0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_kind    = out_reg.frame_kind;
    assign result.crc_good      = out_reg.crc_good;
    assign result.coil_bits     = out_reg.coil_bits;
    assign result.input_bits    = out_reg.input_bits;
    assign result.stop_button   = out_reg.input_bits[0];
    assign result.barrier_touch = out_reg.input_bits[1];
    assign result.analog_ch0    = out_reg.analog_ch0;
    assign result.analog_ch1    = out_reg.analog_ch1;
    assign result.analog_ch2    = out_reg.analog_ch2;
    assign result.analog_ch3    = out_reg.analog_ch3;
    assign result.good_reads    = out_reg.good_reads;

    // Parser and end-of-frame sequencer.
    mrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_mode   (rx.mode),
        .in_byte   (rx.rx_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .crc_ctl   (crc_ctl),
        .crc_data  (crc_data),
        .crc_val   (crc_val),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Shared CRC-16 unit.
    mrp_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (crc_data),
        .crc   (crc_val)
    );

    // Frame store.
    mrp_ram #(
        .WIDTH (8),
        .DEPTH (mrp_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/core/mrp_checker.sv
// Port-level checks of the Modbus RTU response parser and their binding to the top level.
module mrp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [1:0]  frame_kind,
    input  logic        crc_good,
    input  logic [7:0]  input_bits,
    input  logic        stop_button,
    input  logic        barrier_touch,
    input  logic [15:0] good_reads
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(frame_kind) && $stable(crc_good) && $stable(good_reads))
        else $error("result payload changed while stalled");

    // Flags follow the held input bits.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> stop_button == input_bits[0] && barrier_touch == input_bits[1])
        else $error("stop or barrier flag disagrees with input bits");

    // Each frame adds at most one good read, so the count steps by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(good_reads) |-> good_reads == $past(good_reads) + 16'd1)
        else $error("good read count jumped");

endmodule

bind modbus_rtu_response_parser_unit mrp_checker u_mrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .frame_kind    (result.frame_kind),
    .crc_good      (result.crc_good),
    .input_bits    (result.input_bits),
    .stop_button   (result.stop_button),
    .barrier_touch (result.barrier_touch),
    .good_reads    (result.good_reads)
);

>>> tb/tb_modbus_rtu_response_parser_unit.sv
// Self-checking testbench for the Modbus RTU response parser: frames in, predicted results checked.
`timescale 1ns / 100ps

module tb_modbus_rtu_response_parser_unit;

    localparam int          CLK_HALF_NS   = 4;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 800;
    localparam int          TIMEOUT_NS    = 3_200_000;
    localparam logic [15:0] MODBUS_POLY   = 16'hA001;
    localparam logic [15:0] MODBUS_SEED   = 16'hFFFF;
    localparam int          DATA_POS      = 3;

    // Parser phases as the predictor tracks them.
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_FUNC,
        PS_COUNT,
        PS_DATA,
        PS_WRITE,
        PS_LOCK
    } parse_phase_t;

    logic clk;
    logic rst_n;

    mrp_rx_if  rx_if();
    mrp_res_if res_if();
    mrp_cfg_if cfg_if();

    modbus_rtu_response_parser_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Predicted parser state and held data.
    mrp_pkg::cfg_t  cfg_regs;
    parse_phase_t   pstate;
    logic [4:0]     wr_ptr;
    logic [4:0]     body_cnt;
    logic [4:0]     data_len;
    mrp_pkg::kind_t cur_kind;
    logic [7:0]     rx_frame [32];
    logic [7:0]     coil_image;
    logic [7:0]     input_image;
    logic [15:0]    analog_image [4];
    logic [15:0]    read_ok_count;

    // Results still owed by the block, oldest first.
    mrp_pkg::res_t frames_due[$];

    logic [7:0] frame_bytes[$];
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         parsed_bytes   = 0;
    int         src_calm       = 0;
    int         sink_calm      = 0;
    int         hold_off_cycles = 0;
    bit         no_gaps        = 1'b0;

    // Free-running clock.
    always
    begin
        clk = 1'b0;
        #CLK_HALF_NS;
        clk = 1'b1;
        #CLK_HALF_NS;
    end

    // Wait before the next request: mostly random, with calm stretches of none.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
            c = (c >> 1) ^ (c[0] ? MODBUS_POLY : 16'h0000);
        return c;
    endfunction

    function automatic void reset_predictor();
        cfg_regs.slave_address    = mrp_pkg::RST_SLAVE_ADDR;
        cfg_regs.fc_coil_read     = mrp_pkg::RST_FC_COIL;
        cfg_regs.fc_input_read    = mrp_pkg::RST_FC_INPUT;
        cfg_regs.fc_register_read = mrp_pkg::RST_FC_REGISTER;
        cfg_regs.fc_single_write  = mrp_pkg::RST_FC_SINGLE;
        cfg_regs.fc_multi_write   = mrp_pkg::RST_FC_MULTI;
        pstate        = PS_IDLE;
        wr_ptr        = '0;
        body_cnt      = '0;
        data_len      = '0;
        cur_kind      = mrp_pkg::KIND_COIL;
        coil_image    = '0;
        input_image   = '0;
        read_ok_count = '0;
        foreach (rx_frame[i])
            rx_frame[i] = '0;
        foreach (analog_image[i])
            analog_image[i] = '0;
    endfunction

    function automatic void keep_byte(logic [7:0] b);
        rx_frame[wr_ptr] = b;
        wr_ptr = wr_ptr + 5'd1;
    endfunction

    // CRC over the first len stored bytes against the two bytes that follow.
    function automatic bit frame_crc_ok(int len);
        logic [15:0] crc;
        crc = MODBUS_SEED;
        for (int i = 0; i < len; i++)
            crc = crc_step(crc, rx_frame[i]);
        return crc === {rx_frame[len + 1], rx_frame[len]};
    endfunction

    // Frame complete: update held data on a good read and queue the result.
    function automatic void close_frame(mrp_pkg::kind_t k, bit good);
        mrp_pkg::res_t r;
        if (good && k != mrp_pkg::KIND_WRITE)
        begin
            read_ok_count = read_ok_count + 16'd1;
            case (k)
                mrp_pkg::KIND_COIL:  coil_image = rx_frame[DATA_POS];
                mrp_pkg::KIND_INPUT: input_image = rx_frame[DATA_POS];
                default:
                begin
                    for (int ch = 0; ch < 4; ch++)
                        analog_image[ch] = {rx_frame[DATA_POS + 2 * ch],
                                            rx_frame[DATA_POS + 1 + 2 * ch]};
                end
            endcase
        end
        wr_ptr   = '0;
        body_cnt = '0;
        pstate   = PS_IDLE;
        r.frame_kind = k;
        r.crc_good   = good;
        r.coil_bits  = coil_image;
        r.input_bits = input_image;
        r.analog_ch0 = analog_image[0];
        r.analog_ch1 = analog_image[1];
        r.analog_ch2 = analog_image[2];
        r.analog_ch3 = analog_image[3];
        r.good_reads = read_ok_count;
        frames_due.push_back(r);
    endfunction

    // Advance the predicted parser by one accepted request.
    function automatic void step_parser(logic resync, logic [7:0] b);
        if (resync)
        begin
            pstate   = PS_IDLE;
            wr_ptr   = '0;
            body_cnt = '0;
            return;
        end
        case (pstate)
            PS_IDLE:
            begin
                wr_ptr = '0;
                if (b == cfg_regs.slave_address)
                begin
                    keep_byte(b);
                    pstate = PS_FUNC;
                end
                else
                    pstate = PS_LOCK;
            end
            PS_FUNC:
            begin
                keep_byte(b);
                body_cnt = '0;
                // First matching code wins when codes overlap.
                if (b == cfg_regs.fc_coil_read)
                begin
                    cur_kind = mrp_pkg::KIND_COIL;
                    pstate   = PS_COUNT;
                end
                else if (b == cfg_regs.fc_input_read)
                begin
                    cur_kind = mrp_pkg::KIND_INPUT;
                    pstate   = PS_COUNT;
                end
                else if (b == cfg_regs.fc_register_read)
                begin
                    cur_kind = mrp_pkg::KIND_REG;
                    pstate   = PS_COUNT;
                end
                else if (b == cfg_regs.fc_single_write || b == cfg_regs.fc_multi_write)
                begin
                    cur_kind = mrp_pkg::KIND_WRITE;
                    pstate   = PS_WRITE;
                end
                else
                begin
                    wr_ptr = '0;
                    pstate = PS_LOCK;
                end
            end
            PS_COUNT:
            begin
                keep_byte(b);
                body_cnt = '0;
                if (b <= mrp_pkg::MAX_DATA_BYTES)
                begin
                    data_len = 5'(b);
                    pstate   = PS_DATA;
                end
                else
                    pstate = PS_IDLE;
            end
            PS_DATA:
            begin
                keep_byte(b);
                body_cnt = body_cnt + 5'd1;
                if (int'(body_cnt) >= int'(data_len) + 2)
                    close_frame(cur_kind, frame_crc_ok(int'(data_len) + 3));
            end
            PS_WRITE:
            begin
                keep_byte(b);
                body_cnt = body_cnt + 5'd1;
                if (body_cnt >= mrp_pkg::WRITE_BYTES)
                    close_frame(mrp_pkg::KIND_WRITE, frame_crc_ok(int'(mrp_pkg::WRITE_BYTES)));
            end
            default:
            begin
                // Locked: bytes are dropped until a resync.
            end
        endcase
    endfunction

    function automatic logic [7:0] code_of(int sel);
        case (sel)
            0:       return cfg_regs.fc_coil_read;
            1:       return cfg_regs.fc_input_read;
            2:       return cfg_regs.fc_register_read;
            3:       return cfg_regs.fc_single_write;
            default: return cfg_regs.fc_multi_write;
        endcase
    endfunction

    function automatic bit is_known_code(logic [7:0] c);
        return c == cfg_regs.fc_coil_read || c == cfg_regs.fc_input_read ||
               c == cfg_regs.fc_register_read || c == cfg_regs.fc_single_write ||
               c == cfg_regs.fc_multi_write;
    endfunction

    // Mismatch reporting.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result();
        mrp_pkg::res_t want;
        results_seen++;
        if (frames_due.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
            return;
        end
        want = frames_due.pop_front();
        compare_field("frame_kind", res_if.frame_kind, want.frame_kind);
        compare_field("crc_good", res_if.crc_good, want.crc_good);
        compare_field("coil_bits", res_if.coil_bits, want.coil_bits);
        compare_field("input_bits", res_if.input_bits, want.input_bits);
        compare_field("stop_button", res_if.stop_button, want.input_bits[0]);
        compare_field("barrier_touch", res_if.barrier_touch, want.input_bits[1]);
        compare_field("analog_ch0", res_if.analog_ch0, want.analog_ch0);
        compare_field("analog_ch1", res_if.analog_ch1, want.analog_ch1);
        compare_field("analog_ch2", res_if.analog_ch2, want.analog_ch2);
        compare_field("analog_ch3", res_if.analog_ch3, want.analog_ch3);
        compare_field("good_reads", res_if.good_reads, want.good_reads);
    endtask

    // Every accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_result();
    end

    // Result receiver: random stall before each result, one long hold on request.
    initial
    begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(sink_calm);
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
        end
    end

    // Send one request on the byte channel and predict its effect once accepted.
    task automatic send_request(input logic resync, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : draw_wait(src_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.mode    <= resync;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        if (!resync && pstate != PS_LOCK)
            parsed_bytes++;
        step_parser(resync, b);
    endtask

    task automatic resync();
        send_request(1'b1, 8'($urandom));
    endtask

    task automatic rx_release();
        @(negedge clk);
        rx_if.valid <= 1'b0;
    endtask

    // Build a frame for the current slave address; a negative fill means random data.
    task automatic build_frame(input logic [7:0] fc, input int body_len, input bit is_read,
                               input bit corrupt, input int fill);
        logic [15:0] crc;
        int          pos;
        frame_bytes = {};
        frame_bytes.push_back(cfg_regs.slave_address);
        frame_bytes.push_back(fc);
        if (is_read)
            frame_bytes.push_back(8'(body_len));
        repeat (body_len)
            frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        crc = MODBUS_SEED;
        foreach (frame_bytes[i])
            crc = crc_step(crc, frame_bytes[i]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        // Damage one byte past the header so the CRC fails.
        if (corrupt)
        begin
            pos = $urandom_range(is_read ? 3 : 2, frame_bytes.size() - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
    endtask

    task automatic send_frame(input int n_bytes);
        for (int i = 0; i < n_bytes && i < frame_bytes.size(); i++)
            send_request(1'b0, frame_bytes[i]);
    endtask

    task automatic send_read(input int sel, input int len, input bit corrupt, input int fill);
        build_frame(code_of(sel), len, 1'b1, corrupt, fill);
        send_frame(frame_bytes.size());
    endtask

    task automatic send_write(input int sel, input bit corrupt);
        build_frame(code_of(sel), 4, 1'b0, corrupt, -1);
        send_frame(frame_bytes.size());
    endtask

    // Wait until every owed result has come out, then let the block settle.
    task automatic wait_for_idle();
        int waited;
        waited = 0;
        rx_release();
        while (frames_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (frames_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived", frames_due.size()));
            frames_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input mrp_pkg::cfg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            mrp_pkg::CFG_SLAVE_ADDR:  cfg_regs.slave_address    = value;
            mrp_pkg::CFG_FC_COIL:     cfg_regs.fc_coil_read     = value;
            mrp_pkg::CFG_FC_INPUT:    cfg_regs.fc_input_read    = value;
            mrp_pkg::CFG_FC_REGISTER: cfg_regs.fc_register_read = value;
            mrp_pkg::CFG_FC_SINGLE:   cfg_regs.fc_single_write  = value;
            mrp_pkg::CFG_FC_MULTI:    cfg_regs.fc_multi_write   = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Bring the parser to idle, drain it, then load all six registers.
    task automatic change_config(input mrp_pkg::cfg_t c);
        resync();
        wait_for_idle();
        write_register(mrp_pkg::CFG_SLAVE_ADDR, c.slave_address);
        write_register(mrp_pkg::CFG_FC_COIL, c.fc_coil_read);
        write_register(mrp_pkg::CFG_FC_INPUT, c.fc_input_read);
        write_register(mrp_pkg::CFG_FC_REGISTER, c.fc_register_read);
        write_register(mrp_pkg::CFG_FC_SINGLE, c.fc_single_write);
        write_register(mrp_pkg::CFG_FC_MULTI, c.fc_multi_write);
    endtask

    // Good reads of each kind, with the data extremes and the largest byte count.
    task automatic test_good_reads();
        send_read(0, 1, 1'b0, 8'hFF);
        send_read(1, 1, 1'b0, 8'h03);
        send_read(2, 8, 1'b0, -1);
        send_read(0, mrp_pkg::MAX_DATA_BYTES, 1'b0, 8'h00);
        send_read(1, 2, 1'b0, 8'h00);
    endtask

    // Write echoes are reported but change no held data.
    task automatic test_write_echoes();
        send_write(3, 1'b0);
        send_write(4, 1'b0);
        send_write(3, 1'b1);
    endtask

    task automatic test_crc_errors();
        send_read(0, 1, 1'b1, -1);
        send_read(2, 8, 1'b1, -1);
    endtask

    // Short register reads take the analog words partly from older frame bytes.
    task automatic test_short_register_reads();
        send_read(2, 2, 1'b0, -1);
        send_read(2, 0, 1'b0, -1);
    endtask

    task automatic test_lock_and_resync();
        logic [7:0] fc;
        // Foreign address locks the parser; even our own address is then dropped.
        send_request(1'b0, ~cfg_regs.slave_address);
        send_request(1'b0, cfg_regs.slave_address);
        resync();
        // Unknown function code locks as well.
        do
            fc = 8'($urandom);
        while (is_known_code(fc));
        send_request(1'b0, cfg_regs.slave_address);
        send_request(1'b0, fc);
        send_request(1'b0, 8'($urandom));
        resync();
        // A resync in the middle of a frame drops it.
        build_frame(code_of(0), 4, 1'b1, 1'b0, -1);
        send_frame(5);
        resync();
        send_read(0, 1, 1'b0, -1);
    endtask

    // Byte count over the limit returns to idle without a result or a resync.
    task automatic test_count_too_large();
        send_request(1'b0, cfg_regs.slave_address);
        send_request(1'b0, code_of(0));
        send_request(1'b0, 8'(mrp_pkg::MAX_DATA_BYTES + 1));
        send_request(1'b0, cfg_regs.slave_address);
        send_request(1'b0, code_of(1));
        send_request(1'b0, 8'hFF);
        send_read(1, 1, 1'b0, -1);
    endtask

    // With coil and input codes equal, and register and single write equal.
    task automatic test_overlapping_codes();
        send_read(1, 1, 1'b0, -1);
        send_read(2, 8, 1'b0, -1);
        send_write(4, 1'b0);
    endtask

    // Long receiver hold while frames keep coming, so the parser stalls its input.
    task automatic test_output_backpressure();
        no_gaps = 1'b1;
        hold_off_cycles = HOLD_CYCLES;
        repeat (8)
            send_read($urandom_range(0, 2), $urandom_range(0, mrp_pkg::MAX_DATA_BYTES),
                      1'b0, -1);
        no_gaps = 1'b0;
    endtask

    task automatic send_random_frame();
        int         pick;
        int         sel;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pstate != PS_IDLE && $urandom_range(0, 9) != 0)
            resync();
        sel = $urandom_range(0, 4);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, mrp_pkg::MAX_DATA_BYTES)
                                          : $urandom_range(0, 8);
        if (pick < 72)
        begin
            // Well-formed frame, occasionally with a CRC error.
            if (sel < 3)
                send_read(sel, len, $urandom_range(0, 7) == 0, -1);
            else
                send_write(sel, $urandom_range(0, 7) == 0);
        end
        else if (pick < 79)
        begin
            do
                b = 8'($urandom);
            while (b == cfg_regs.slave_address);
            send_request(1'b0, b);
            repeat ($urandom_range(0, 4))
                send_request(1'b0, 8'($urandom));
        end
        else if (pick < 86)
        begin
            do
                b = 8'($urandom);
            while (is_known_code(b));
            send_request(1'b0, cfg_regs.slave_address);
            send_request(1'b0, b);
            repeat ($urandom_range(0, 4))
                send_request(1'b0, 8'($urandom));
        end
        else if (pick < 91)
        begin
            send_request(1'b0, cfg_regs.slave_address);
            send_request(1'b0, code_of($urandom_range(0, 2)));
            send_request(1'b0, 8'($urandom_range(mrp_pkg::MAX_DATA_BYTES + 1, 255)));
        end
        else if (pick < 96)
        begin
            // Truncated frame cut off by a resync.
            build_frame(code_of(sel), sel < 3 ? len : 4, sel < 3, 1'b0, -1);
            send_frame($urandom_range(1, frame_bytes.size() - 1));
            resync();
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_request(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        stop_at = parsed_bytes + n_items;
        while (parsed_bytes < stop_at)
            send_random_frame();
    endtask

    function automatic mrp_pkg::cfg_t random_config();
        mrp_pkg::cfg_t c;
        c.slave_address    = 8'($urandom);
        c.fc_coil_read     = 8'($urandom);
        c.fc_input_read    = 8'($urandom);
        c.fc_register_read = 8'($urandom);
        c.fc_single_write  = 8'($urandom);
        c.fc_multi_write   = 8'($urandom);
        return c;
    endfunction

    // Main sequence.
    initial
    begin : main_sequence
        mrp_pkg::cfg_t c;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.mode     = 1'b0;
        rx_if.rx_byte  = 8'h00;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = mrp_pkg::CFG_SLAVE_ADDR;
        cfg_if.data    = 8'h00;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_reads();
        test_write_echoes();
        test_crc_errors();
        test_short_register_reads();
        test_lock_and_resync();
        test_count_too_large();
        test_random_traffic(300);

        // Low extremes and overlapping function codes.
        c.slave_address    = 8'h00;
        c.fc_coil_read     = 8'hFF;
        c.fc_input_read    = 8'hFF;
        c.fc_register_read = 8'h00;
        c.fc_single_write  = 8'h00;
        c.fc_multi_write   = 8'h10;
        change_config(c);
        test_overlapping_codes();
        test_random_traffic(200);

        // Top slave address with the usual function codes.
        c.slave_address    = 8'hFF;
        c.fc_coil_read     = 8'h01;
        c.fc_input_read    = 8'h02;
        c.fc_register_read = 8'h03;
        c.fc_single_write  = 8'h05;
        c.fc_multi_write   = 8'h0F;
        change_config(c);
        test_output_backpressure();
        test_random_traffic(300);

        repeat (2)
        begin
            change_config(random_config());
            test_random_traffic(200);
        end

        wait_for_idle();
        if (mismatch_count == 0)
            $display("tb_modbus_rtu_response_parser_unit passed");
        else
            $display("tb_modbus_rtu_response_parser_unit failed");
        $finish;
    end

    // Run limit.
    initial
    begin : run_limit
        #TIMEOUT_NS;
        $display("tb_modbus_rtu_response_parser_unit failed");
        $finish;
    end

endmodule
